// ----- sv/wdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Weight display formatter package
// Unit codes, division constants, ASCII codes and the pipeline word type
// shared by the formatter core.
// ----------------------------------------------------------------------------
package wdf_pkg;

    // Display unit codes, as held in the configuration register.
    typedef enum logic [1:0] {
        UNIT_KG = 2'd0,
        UNIT_LB = 2'd1,
        UNIT_ST = 2'd2
    } unit_t;

    // Saturation limits of the input weight in grams.
    localparam logic signed [19:0] W_MIN = -20'sd9000;
    localparam logic signed [19:0] W_MAX = 20'sd450000;

    // Kilos: tenths of a kilogram, weight / 100 rounded half away from zero.
    localparam logic [12:0] DIV_KG   = 13'd100;
    localparam logic [25:0] ROUND_KG = 26'd50;
    localparam logic [13:0] RECIP_KG = 14'd5242;   // floor(2^19 / 100)

    // Pounds: tenths of a pound, weight * 100 / 4536 rounded likewise.
    localparam logic [12:0] DIV_LB   = 13'd4536;
    localparam logic [25:0] ROUND_LB = 26'd2268;
    localparam logic [25:0] MUL_LB   = 26'd100;
    localparam logic [13:0] RECIP_LB = 14'd14794;  // floor(2^26 / 4536)

    // Stones: 140 tenth-pounds to the stone.
    localparam logic [13:0] STONE_TP = 14'd140;
    localparam logic [13:0] RECIP_ST = 14'd117;    // floor(2^14 / 140)

    // Reciprocals for division by ten.
    localparam logic [15:0] RECIP_TEN_W = 16'd52429; // x * 52429 >> 19
    localparam logic [7:0]  RECIP_TEN_N = 8'd205;    // x * 205 >> 11, x < 1029

    // ASCII codes.
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    // Word carried from stage to stage; each stage fills in its own fields.
    typedef struct packed {
        logic        neg;    // weight is negative and the magnitude nonzero
        unit_t       unit;
        logic [25:0] num;    // rounded numerator of the first division
        logic [13:0] est;    // quotient estimate, low by at most one
        logic [13:0] mag;    // magnitude of the kilo or tenth-pound value
        logic [9:0]  q1;     // mag / 10
        logic [6:0]  q2;     // mag / 100
        logic [3:0]  q3;     // mag / 1000
        logic [3:0]  dig0;
        logic [3:0]  dig1;
        logic [3:0]  dig2;
        logic [6:0]  ste;    // stones estimate
        logic [6:0]  st;     // whole stones
        logic [7:0]  rem;    // tenth-pounds left over
        logic [3:0]  lb;     // whole pounds
        logic [2:0]  st_t;   // stones tens digit
        logic [3:0]  st_o;   // stones ones digit
        logic        lb_t;   // pounds tens digit
        logic [3:0]  lb_o;   // pounds ones digit
    } pipe_t;

endpackage

// ----- sv/weight_display_formatter_core.sv -----
// ----------------------------------------------------------------------------
// Weight display formatter core
// Throughput: one weight per cycle; busy is held low, since every stage of
// the eight-stage pipeline advances on every clock.
// Reset clears the stage valid bits, the done strobe and units_reg.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module weight_display_formatter_core
    import wdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [19:0] weight_grams,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    output logic               done,
    output logic [6:0]         char_first,
    output logic [6:0]         char_second,
    output logic [6:0]         char_third,
    output logic [6:0]         char_fourth,
    output logic [1:0]         unit_flag
);

    localparam int NSTAGE = 7;

    logic [1:0]        units_reg;
    logic [NSTAGE:0]   valid_reg;
    logic [NSTAGE:0]   valid_next;
    pipe_t             stage_reg  [1:NSTAGE];
    pipe_t             stage_next [1:NSTAGE];

    logic signed [19:0] w_clamp;
    logic [19:0]        w_abs;
    unit_t              unit_sel;
    logic [13:0]        recip2;
    logic [39:0]        prod2;
    logic [12:0]        div3;
    logic [26:0]        prod3;
    logic [25:0]        rem3;
    logic [13:0]        mag3;
    logic [29:0]        prod4a;
    logic [20:0]        prod4b;
    logic [13:0]        diff5;
    logic [25:0]        prod5;
    logic [13:0]        stp5;
    logic [13:0]        r5;
    logic [8:0]         r5n;
    logic [9:0]         diff6;
    logic [14:0]        prod6a;
    logic [7:0]         rem6;
    logic [15:0]        prod6b;
    logic [14:0]        prod6c;
    logic [6:0]         diff7a;
    logic [6:0]         diff7b;

    logic [6:0] c0_next, c1_next, c2_next, c3_next;
    logic [6:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [1:0] flag_reg;
    logic       neg_st, neg_lb;

    function automatic logic [6:0] dchar(input logic [3:0] d);
        return CHAR_ZERO + {3'b000, d};
    endfunction

    // Every stage advances each cycle, so a new word is always welcome.
    assign busy = 1'b0;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= UNIT_KG;
        end
        else if (cfg_wr_en)
        begin
            units_reg <= cfg_wr_data;
        end
    end

    // Unit decode; the unused code shows kilos.
    always_comb
    begin
        unique case (units_reg)
            UNIT_LB: unit_sel = UNIT_LB;
            UNIT_ST: unit_sel = UNIT_ST;
            default: unit_sel = UNIT_KG;
        endcase
    end

    // Stage 1: saturate, take the magnitude and form the rounded numerator.
    always_comb
    begin
        w_clamp = weight_grams;
        if (weight_grams < W_MIN)
        begin
            w_clamp = W_MIN;
        end
        else if (weight_grams > W_MAX)
        begin
            w_clamp = W_MAX;
        end
        w_abs = w_clamp[19] ? -w_clamp : w_clamp;

        stage_next[1]      = '0;
        stage_next[1].neg  = w_clamp[19];
        stage_next[1].unit = unit_sel;
        if (unit_sel == UNIT_KG)
        begin
            stage_next[1].num = {7'b0, w_abs[18:0]} + ROUND_KG;
        end
        else
        begin
            stage_next[1].num = {7'b0, w_abs[18:0]} * MUL_LB + ROUND_LB;
        end
    end

    // Stage 2: quotient estimate by reciprocal multiplication.
    always_comb
    begin
        stage_next[2] = stage_reg[1];
        recip2 = (stage_reg[1].unit == UNIT_KG) ? RECIP_KG : RECIP_LB;
        prod2  = {14'b0, stage_reg[1].num} * {26'b0, recip2};
        if (stage_reg[1].unit == UNIT_KG)
        begin
            stage_next[2].est = prod2[32:19];
        end
        else
        begin
            stage_next[2].est = prod2[39:26];
        end
    end

    // Stage 3: correct the estimate by one where the remainder allows.
    always_comb
    begin
        stage_next[3] = stage_reg[2];
        div3  = (stage_reg[2].unit == UNIT_KG) ? DIV_KG : DIV_LB;
        prod3 = {13'b0, stage_reg[2].est} * {14'b0, div3};
        rem3  = stage_reg[2].num - prod3[25:0];
        mag3  = stage_reg[2].est + ((rem3 >= {13'b0, div3}) ? 14'd1 : 14'd0);
        stage_next[3].mag = mag3;
        stage_next[3].neg = stage_reg[2].neg && (mag3 != 14'd0);
    end

    // Stage 4: first division by ten and the stones estimate.
    always_comb
    begin
        stage_next[4] = stage_reg[3];
        prod4a = {16'b0, stage_reg[3].mag} * {14'b0, RECIP_TEN_W};
        prod4b = {7'b0, stage_reg[3].mag} * {7'b0, RECIP_ST};
        stage_next[4].q1  = prod4a[28:19];
        stage_next[4].ste = prod4b[20:14];
    end

    // Stage 5: ones digit, second division by ten, stones correction.
    always_comb
    begin
        stage_next[5] = stage_reg[4];
        diff5 = stage_reg[4].mag - ({1'b0, stage_reg[4].q1, 3'b000}
                                  + {3'b000, stage_reg[4].q1, 1'b0});
        stage_next[5].dig0 = diff5[3:0];
        prod5 = {16'b0, stage_reg[4].q1} * {10'b0, RECIP_TEN_W};
        stage_next[5].q2 = prod5[25:19];

        stp5 = {7'b0, stage_reg[4].ste} * STONE_TP;
        r5   = stage_reg[4].mag - stp5;
        r5n  = r5[8:0] - STONE_TP[8:0];
        if (r5[8:0] >= STONE_TP[8:0])
        begin
            stage_next[5].st  = stage_reg[4].ste + 7'd1;
            stage_next[5].rem = r5n[7:0];
        end
        else
        begin
            stage_next[5].st  = stage_reg[4].ste;
            stage_next[5].rem = r5[7:0];
        end
    end

    // Stage 6: tens digit, thousands quotient, whole pounds, stones tens.
    always_comb
    begin
        stage_next[6] = stage_reg[5];
        diff6 = stage_reg[5].q1 - ({stage_reg[5].q2, 3'b000}
                                 + {2'b00, stage_reg[5].q2, 1'b0});
        stage_next[6].dig1 = diff6[3:0];
        prod6a = {8'b0, stage_reg[5].q2} * {7'b0, RECIP_TEN_N};
        stage_next[6].q3 = prod6a[14:11];
        rem6   = stage_reg[5].rem + 8'd5;
        prod6b = {8'b0, rem6} * {8'b0, RECIP_TEN_N};
        stage_next[6].lb = prod6b[14:11];
        prod6c = {8'b0, stage_reg[5].st} * {7'b0, RECIP_TEN_N};
        stage_next[6].st_t = prod6c[13:11];
    end

    // Stage 7: remaining digits of every field.
    always_comb
    begin
        stage_next[7] = stage_reg[6];
        diff7a = stage_reg[6].q2 - ({stage_reg[6].q3, 3'b000}
                                  + {2'b00, stage_reg[6].q3, 1'b0});
        stage_next[7].dig2 = diff7a[3:0];
        diff7b = stage_reg[6].st - ({1'b0, stage_reg[6].st_t, 3'b000}
                                  + {3'b000, stage_reg[6].st_t, 1'b0});
        stage_next[7].st_o = diff7b[3:0];
        stage_next[7].lb_t = (stage_reg[6].lb >= 4'd10);
        stage_next[7].lb_o = (stage_reg[6].lb >= 4'd10) ? stage_reg[6].lb - 4'd10
                                                        : stage_reg[6].lb;
    end

    // Stage 8: lay the digits out as display text.
    always_comb
    begin
        neg_st = stage_reg[7].neg
                 && ((stage_reg[7].st_t != 3'd0) || (stage_reg[7].st_o != 4'd0));
        neg_lb = stage_reg[7].neg && (stage_reg[7].lb_t || (stage_reg[7].lb_o != 4'd0));
        c0_next = CHAR_SPACE;
        c1_next = CHAR_SPACE;
        c2_next = dchar(stage_reg[7].dig1);
        c3_next = dchar(stage_reg[7].dig0);
        if (stage_reg[7].unit == UNIT_ST)
        begin
            // Stones field, then a zero-padded pounds field with its own sign.
            if (neg_st)
            begin
                c0_next = CHAR_MINUS;
            end
            else if (stage_reg[7].st_t != 3'd0)
            begin
                c0_next = dchar({1'b0, stage_reg[7].st_t});
            end
            c1_next = dchar(stage_reg[7].st_o);
            if (neg_lb)
            begin
                c2_next = CHAR_MINUS;
                c3_next = stage_reg[7].lb_t ? dchar(4'd1) : dchar(stage_reg[7].lb_o);
            end
            else
            begin
                c2_next = dchar({3'b000, stage_reg[7].lb_t});
                c3_next = dchar(stage_reg[7].lb_o);
            end
        end
        else if (stage_reg[7].q3 != 4'd0)
        begin
            c0_next = dchar(stage_reg[7].q3);
            c1_next = dchar(stage_reg[7].dig2);
        end
        else if (stage_reg[7].dig2 != 4'd0)
        begin
            c0_next = stage_reg[7].neg ? CHAR_MINUS : CHAR_SPACE;
            c1_next = dchar(stage_reg[7].dig2);
        end
        else if (stage_reg[7].dig1 != 4'd0)
        begin
            c1_next = stage_reg[7].neg ? CHAR_MINUS : CHAR_SPACE;
        end
        else
        begin
            // A single digit always gets a leading zero.
            c1_next = stage_reg[7].neg ? CHAR_MINUS : CHAR_SPACE;
            c2_next = CHAR_ZERO;
        end
    end

    // Valid bits travel alongside the words.
    always_comb
    begin
        valid_next = {valid_reg[NSTAGE-1:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Pipeline and output words.
    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= NSTAGE; k++)
        begin
            stage_reg[k] <= stage_next[k];
        end
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        c3_reg   <= c3_next;
        flag_reg <= 2'(stage_reg[7].unit);
    end

    assign done        = valid_reg[NSTAGE];
    assign char_first  = c0_reg;
    assign char_second = c1_reg;
    assign char_third  = c2_reg;
    assign char_fourth = c3_reg;
    assign unit_flag   = flag_reg;

endmodule

// ----- tb/weight_display_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weight display checker
// Watches the weight and result words of the formatter core, works out the
// four display characters and the unit flag of every accepted weight, and
// compares each result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module weight_display_checker
    import wdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [19:0] weight_grams,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               done,
    input  logic [6:0]         char_first,
    input  logic [6:0]         char_second,
    input  logic [6:0]         char_third,
    input  logic [6:0]         char_fourth,
    input  logic [1:0]         unit_flag,
    output int                 mismatches,
    output int                 texts_owed
);

    // Scaling constants of the three display units.
    localparam int GRAMS_PER_TENTH_KG = 100;
    localparam int TENTH_LB_SCALE     = 100;
    localparam int GRAMS_SCALED_PER_TENTH_LB = 4536;
    localparam int TENTH_LB_PER_STONE = 140;
    localparam int TENTH_LB_PER_LB    = 10;

    typedef struct packed {
        logic [6:0] ch_first;
        logic [6:0] ch_second;
        logic [6:0] ch_third;
        logic [6:0] ch_fourth;
        logic [1:0] flag;
    } lcd_text_t;

    // Up to four characters of decimal text, leftmost in the low bits.
    typedef struct packed {
        logic [27:0] chars;
        int          len;
    } num_text_t;

    lcd_text_t lcd_text_q [$];
    logic [1:0] units_q;
    int         bad_now;
    lcd_text_t  owed;

    // Division by a positive constant, rounding halves away from zero.
    function automatic int round_half_away(input int n, input int d);
        return (n < 0) ? (n - d / 2) / d : (n + d / 2) / d;
    endfunction

    // Decimal text of v at least width characters wide; padding is spaces
    // ahead of the sign, or zeros after it when zero_pad is set.
    function automatic num_text_t decimal_text(input int v, input int width,
                                               input bit zero_pad);
        num_text_t  f;
        logic [27:0] txt;
        int mag, nd, pad, t, i, k, n;
        txt = {4{CHAR_SPACE}};
        n = 0;
        mag = (v < 0) ? -v : v;
        nd = 1;
        t = mag / 10;
        while (t != 0)
        begin
            nd++;
            t = t / 10;
        end
        pad = width - nd - ((v < 0) ? 1 : 0);
        if (pad < 0)
            pad = 0;
        if (!zero_pad)
            for (i = 0; i < pad; i++)
            begin
                txt[n*7 +: 7] = CHAR_SPACE;
                n++;
            end
        if (v < 0)
        begin
            txt[n*7 +: 7] = CHAR_MINUS;
            n++;
        end
        if (zero_pad)
            for (i = 0; i < pad; i++)
            begin
                txt[n*7 +: 7] = CHAR_ZERO;
                n++;
            end
        for (i = nd - 1; i >= 0; i--)
        begin
            t = mag;
            for (k = 0; k < i; k++)
                t = t / 10;
            txt[n*7 +: 7] = CHAR_ZERO + 7'(t % 10);
            n++;
        end
        f.chars = txt;
        f.len = n;
        return f;
    endfunction

    // Display text and annunciator for one weight under the given units.
    function automatic lcd_text_t render_weight(input logic signed [19:0] weight_in,
                                                input logic [1:0] units);
        lcd_text_t   r;
        num_text_t   head;
        num_text_t   tail;
        logic [55:0] txt;
        int w, tenth_lb, v, i;
        w = weight_in;
        if (w < W_MIN)
            w = W_MIN;
        if (w > W_MAX)
            w = W_MAX;
        txt = {8{CHAR_SPACE}};
        tail.chars = '0;
        tail.len = 0;
        if (units == UNIT_ST)
        begin
            // Whole stones truncate; the pounds left over are rounded.
            tenth_lb = round_half_away(w * TENTH_LB_SCALE, GRAMS_SCALED_PER_TENTH_LB);
            head = decimal_text(tenth_lb / TENTH_LB_PER_STONE, 2, 1'b0);
            tail = decimal_text(round_half_away(tenth_lb % TENTH_LB_PER_STONE,
                                                TENTH_LB_PER_LB), 2, 1'b1);
            r.flag = UNIT_ST;
        end
        else
        begin
            if (units == UNIT_LB)
            begin
                v = round_half_away(w * TENTH_LB_SCALE, GRAMS_SCALED_PER_TENTH_LB);
                r.flag = UNIT_LB;
            end
            else
            begin
                v = round_half_away(w, GRAMS_PER_TENTH_KG);
                r.flag = UNIT_KG;
            end
            head = decimal_text(v, 4, 1'b0);
        end
        for (i = 0; i < head.len; i++)
            txt[i*7 +: 7] = head.chars[i*7 +: 7];
        for (i = 0; i < tail.len; i++)
            txt[(head.len + i)*7 +: 7] = tail.chars[i*7 +: 7];
        // A lone digit or a minus and a digit get a leading zero.
        if (units != UNIT_ST && txt[6:0] == CHAR_SPACE && txt[13:7] == CHAR_SPACE)
        begin
            if (txt[20:14] == CHAR_SPACE)
                txt[20:14] = CHAR_ZERO;
            else if (txt[20:14] == CHAR_MINUS)
            begin
                txt[20:14] = CHAR_ZERO;
                txt[13:7] = CHAR_MINUS;
            end
        end
        r.ch_first  = txt[6:0];
        r.ch_second = txt[13:7];
        r.ch_third  = txt[20:14];
        r.ch_fourth = txt[27:21];
        return r;
    endfunction

    function automatic int field_differs(input string name, input int want,
                                         input int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // Retire result words against predictions, then queue the new weight.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_q <= UNIT_KG;
            mismatches <= 0;
            texts_owed <= 0;
            lcd_text_q.delete();
        end
        else
        begin
            bad_now = mismatches;
            if (done)
            begin
                if (lcd_text_q.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual %h %h %h %h %h",
                             $time, char_first, char_second, char_third, char_fourth,
                             unit_flag);
                    bad_now++;
                end
                else
                begin
                    owed = lcd_text_q.pop_front();
                    bad_now += field_differs("char_first", owed.ch_first, char_first);
                    bad_now += field_differs("char_second", owed.ch_second, char_second);
                    bad_now += field_differs("char_third", owed.ch_third, char_third);
                    bad_now += field_differs("char_fourth", owed.ch_fourth, char_fourth);
                    bad_now += field_differs("unit_flag", owed.flag, unit_flag);
                end
            end
            if (start && !busy)
                lcd_text_q.push_back(render_weight(weight_grams, units_q));
            if (cfg_wr_en)
                units_q <= cfg_wr_data;
            mismatches <= bad_now;
            texts_owed <= lcd_text_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weight display formatter testbench
// Drives directed and random weights through the formatter core under every
// unit setting, with phases of random sender gaps, and leaves the checking of
// each result word to the checker beside the core.
// ----------------------------------------------------------------------------
module tb;
    import wdf_pkg::*;

    localparam int PIPE_LATENCY      = 8;
    localparam int WATCHDOG_LIMIT    = 1000;
    localparam int RANDOM_PHASES     = 8;
    localparam int WEIGHTS_PER_PHASE = 106;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [19:0] weight_grams;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_data;
    logic               done;
    logic [6:0]         char_first;
    logic [6:0]         char_second;
    logic [6:0]         char_third;
    logic [6:0]         char_fourth;
    logic [1:0]         unit_flag;
    int                 mismatches;
    int                 texts_owed;

    always #5 clk = ~clk;

    weight_display_formatter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .weight_grams(weight_grams),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .char_first  (char_first),
        .char_second (char_second),
        .char_third  (char_third),
        .char_fourth (char_fourth),
        .unit_flag   (unit_flag)
    );

    weight_display_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .weight_grams(weight_grams),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .char_first  (char_first),
        .char_second (char_second),
        .char_third  (char_third),
        .char_fourth (char_fourth),
        .unit_flag   (unit_flag),
        .mismatches  (mismatches),
        .texts_owed  (texts_owed)
    );

    // Offer one weight after a random gap and hold it until it is taken.
    task automatic send_weight(input logic signed [19:0] w, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        weight_grams <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (texts_owed != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_units(input logic [1:0] units);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= units;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly in-range weights, many of them small, and some of any value.
    function automatic logic signed [19:0] random_weight();
        int unsigned pick;
        logic signed [19:0] w;
        pick = $urandom_range(99);
        if (pick < 15)
            w = 20'($urandom);
        else if (pick < 60)
            w = 20'($urandom_range(459000) - 9000);
        else
            w = 20'($urandom_range(12500) - 9500);
        return w;
    endfunction

    // Ends the run if no word moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || cfg_wr_en || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int n;
        int idle_pct;
        rst_n <= 1'b0;
        start <= 1'b0;
        weight_grams <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= UNIT_KG;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Kilos from reset: rounding at half, small values and saturation.
        send_weight(0, 0);
        send_weight(49, 0);
        send_weight(50, 0);
        send_weight(-50, 0);
        send_weight(-950, 0);
        send_weight(450000, 0);
        send_weight(524287, 0);
        send_weight(-524288, 0);

        // Pounds: lone digits with and without a sign, range ends.
        write_units(UNIT_LB);
        send_weight(0, 0);
        send_weight(23, 0);
        send_weight(-23, 0);
        send_weight(-9000, 0);
        send_weight(450000, 0);
        send_weight(450001, 0);
        send_weight(45359, 0);
        send_weight(-1000, 0);

        // Stones: carry into a stone, negative pounds and overlong text.
        write_units(UNIT_ST);
        send_weight(0, 0);
        send_weight(6305, 0);
        send_weight(6350, 0);
        send_weight(-2000, 0);
        send_weight(-5000, 0);
        send_weight(-9000, 0);
        send_weight(63000, 0);
        send_weight(450000, 0);
        send_weight(-9001, 0);

        // Random phases over every unit code, the unused one included.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_units(2'((p + 1) % 4));
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 53;
                default: idle_pct = 19;
            endcase
            for (n = 0; n < WEIGHTS_PER_PHASE; n++)
                send_weight(random_weight(), idle_pct);
        end

        drain_results();
        if (mismatches == 0 && texts_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
